FILE: rtl/rne_pkg.sv
// Package for the Roman numeral encoder: microcode format, program ROM and shared types.
package rne_pkg;

  localparam int unsigned VALUE_W = 12;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned K_W     = 10;
  localparam int unsigned PC_W    = 5;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd4000;

  localparam logic [CHAR_W-1:0] CHAR_M  = 8'h4D;
  localparam logic [CHAR_W-1:0] CHAR_D  = 8'h44;
  localparam logic [CHAR_W-1:0] CHAR_C  = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_L  = 8'h4C;
  localparam logic [CHAR_W-1:0] CHAR_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CHAR_V  = 8'h56;
  localparam logic [CHAR_W-1:0] CHAR_I  = 8'h49;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    OP_LOOP, // emit and subtract while rem >= k, then fall through
    OP_TEST, // rem >= k: emit, next; else jump to tgt
    OP_SUB,  // emit, subtract k, next
    OP_ONCE, // rem >= k: emit and subtract; next either way
    OP_END   // emit line feed with last, done
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [K_W-1:0]   k;
    logic [CHAR_W-1:0] ch;
    logic [PC_W-1:0]  tgt;
  } ucode_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } emit_t;

  function automatic ucode_t mk(op_t op, logic [K_W-1:0] k, logic [CHAR_W-1:0] ch,
                                logic [PC_W-1:0] tgt);
    ucode_t w;
    w.op  = op;
    w.k   = k;
    w.ch  = ch;
    w.tgt = tgt;
    return w;
  endfunction

  function automatic ucode_t ucode_word(logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:    w = mk(OP_LOOP, 10'd1000, CHAR_M, 5'd0);
      5'd1:    w = mk(OP_TEST, 10'd900,  CHAR_C, 5'd3);
      5'd2:    w = mk(OP_SUB,  10'd900,  CHAR_M, 5'd0);
      5'd3:    w = mk(OP_ONCE, 10'd500,  CHAR_D, 5'd0);
      5'd4:    w = mk(OP_TEST, 10'd400,  CHAR_C, 5'd6);
      5'd5:    w = mk(OP_SUB,  10'd400,  CHAR_D, 5'd0);
      5'd6:    w = mk(OP_LOOP, 10'd100,  CHAR_C, 5'd0);
      5'd7:    w = mk(OP_TEST, 10'd90,   CHAR_X, 5'd9);
      5'd8:    w = mk(OP_SUB,  10'd90,   CHAR_C, 5'd0);
      5'd9:    w = mk(OP_ONCE, 10'd50,   CHAR_L, 5'd0);
      5'd10:   w = mk(OP_TEST, 10'd40,   CHAR_X, 5'd12);
      5'd11:   w = mk(OP_SUB,  10'd40,   CHAR_L, 5'd0);
      5'd12:   w = mk(OP_LOOP, 10'd10,   CHAR_X, 5'd0);
      5'd13:   w = mk(OP_TEST, 10'd9,    CHAR_I, 5'd15);
      5'd14:   w = mk(OP_SUB,  10'd9,    CHAR_X, 5'd0);
      5'd15:   w = mk(OP_ONCE, 10'd5,    CHAR_V, 5'd0);
      5'd16:   w = mk(OP_TEST, 10'd4,    CHAR_I, 5'd18);
      5'd17:   w = mk(OP_SUB,  10'd4,    CHAR_V, 5'd0);
      5'd18:   w = mk(OP_LOOP, 10'd1,    CHAR_I, 5'd0);
      default: w = mk(OP_END,  10'd0,    CHAR_LF, 5'd0);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/rne_seq.sv
// Microcoded sequencer and remainder datapath of the Roman numeral encoder.
module rne_seq
  import rne_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] start_value,
  input  logic               advance,
  output logic               busy,
  output emit_t              emit
);

  logic [PC_W-1:0]    pc, pc_next;
  logic [VALUE_W-1:0] rem, rem_next;
  logic               busy_next;
  ucode_t             word;
  logic               ge;
  logic [VALUE_W-1:0] k_ext;

  assign word  = ucode_word(pc);
  assign k_ext = {{(VALUE_W-K_W){1'b0}}, word.k};
  assign ge    = rem >= k_ext;

  always_comb begin
    pc_next    = pc;
    rem_next   = rem;
    busy_next  = busy;
    emit.valid = 1'b0;
    emit.ch    = word.ch;
    emit.last  = 1'b0;
    if (start) begin
      busy_next = 1'b1;
      pc_next   = '0;
      rem_next  = start_value;
    end else if (busy && advance) begin
      case (word.op)
        OP_LOOP: begin
          if (ge) begin
            emit.valid = 1'b1;
            rem_next   = rem - k_ext;
          end else begin
            pc_next = pc + 1'b1;
          end
        end
        OP_TEST: begin
          if (ge) begin
            emit.valid = 1'b1;
            pc_next    = pc + 1'b1;
          end else begin
            pc_next = word.tgt;
          end
        end
        OP_SUB: begin
          emit.valid = 1'b1;
          rem_next   = rem - k_ext;
          pc_next    = pc + 1'b1;
        end
        OP_ONCE: begin
          if (ge) begin
            emit.valid = 1'b1;
            rem_next   = rem - k_ext;
          end
          pc_next = pc + 1'b1;
        end
        OP_END: begin
          emit.valid = 1'b1;
          emit.last  = 1'b1;
          busy_next  = 1'b0;
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
    rem <= rem_next;
  end

endmodule

FILE: rtl/roman_numeral_encoder.sv
// Roman numeral encoder: one 12-bit number in, its numeral as ASCII words plus line feed out.
// The sequencer runs one microcode step per character word or skipped step, and it stalls while
//   the output register holds a word that is not yet taken; the step counter walks the program.
//   A new number is accepted only once the line feed is emitted and busy drops.
// Numbers of 4000 and above are accepted and dropped; the next one is taken the cycle after.
// Reset (rst, synchronous) empties the sequencer and the output register.
module roman_numeral_encoder
  import rne_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               char_valid,
  input  logic               char_ready,
  output logic [CHAR_W-1:0]  character,
  output logic               last
);

  logic  busy;
  logic  advance;
  logic  start;
  emit_t emit;

  assign item_ready = !busy;
  assign start      = item_valid && item_ready && (value < VALUE_LIMIT);
  assign advance    = !char_valid || char_ready;

  rne_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .start_value (value),
    .advance     (advance),
    .busy        (busy),
    .emit        (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (advance) begin
      char_valid <= emit.valid;
    end
    if (emit.valid) begin
      character <= emit.ch;
      last      <= emit.last;
    end
  end

endmodule

FILE: sim/roman_numeral_encoder_test.sv
`timescale 1ns / 1ps
// Testbench for roman_numeral_encoder: directed and random numbers, numeral words checked in order.
module roman_numeral_encoder_test;
  import rne_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } numeral_word_t;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_LITERAL,
    ROW_DROPPED
  } row_kind_t;

  localparam int RANDOM_COUNT = 448;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 150;
  localparam int PAUSE_AT     = 100;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [VALUE_W-1:0] value = '0;
  logic               char_valid;
  logic               char_ready = 1'b0;
  logic [CHAR_W-1:0]  character;
  logic               last;

  numeral_word_t      expected_words[$];
  int                 error_count = 0;
  int                 words_seen = 0;

  logic [VALUE_W-1:0] row_value[$];
  row_kind_t          row_kind[$];
  string              row_text[$];

  roman_numeral_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .value      (value),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .last       (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic void push_word(input logic [CHAR_W-1:0] ch, input logic is_last);
    numeral_word_t w;
    w.ch   = ch;
    w.last = is_last;
    expected_words.push_back(w);
  endfunction

  function automatic void add_digit_symbols(input int d, input logic [CHAR_W-1:0] unit_ch,
                                            input logic [CHAR_W-1:0] five_ch,
                                            input logic [CHAR_W-1:0] ten_ch);
    int r;
    r = d;
    if (d == 9) begin
      push_word(unit_ch, 1'b0);
      push_word(ten_ch, 1'b0);
    end else if (d == 4) begin
      push_word(unit_ch, 1'b0);
      push_word(five_ch, 1'b0);
    end else begin
      if (r >= 5) begin
        push_word(five_ch, 1'b0);
        r -= 5;
      end
      repeat (r) push_word(unit_ch, 1'b0);
    end
  endfunction

  function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
    int n;
    if (v >= VALUE_LIMIT) return;
    n = int'(v);
    repeat (n / 1000) push_word(CHAR_M, 1'b0);
    add_digit_symbols((n / 100) % 10, CHAR_C, CHAR_D, CHAR_M);
    add_digit_symbols((n / 10) % 10, CHAR_X, CHAR_L, CHAR_C);
    add_digit_symbols(n % 10, CHAR_I, CHAR_V, CHAR_X);
    push_word(CHAR_LF, 1'b1);
  endfunction

  function automatic void expect_literal(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
    push_word(CHAR_LF, 1'b1);
  endfunction

  function automatic void add_row(input int v, input row_kind_t kind, input string text);
    row_value.push_back(VALUE_W'(v));
    row_kind.push_back(kind);
    row_text.push_back(text);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return VALUE_W'($urandom_range(4095, 4000));
    if (pick < 18) return VALUE_W'($urandom_range(20));
    if (pick < 63)
      return VALUE_W'($urandom_range(3) * 1000 + $urandom_range(9) * 100 +
                      $urandom_range(9) * 10 + $urandom_range(9));
    return VALUE_W'($urandom_range(3999));
  endfunction

  // no sender gaps in the middle stretch of the random run
  function automatic int idle_gap(input int idx);
    if (idx >= 250 && idx < 330) return 0;
    if ($urandom_range(99) < 20) return $urandom_range(4, 1);
    return 0;
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v, input row_kind_t kind,
                            input string text, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    case (kind)
      ROW_LITERAL: expect_literal(text);
      ROW_DROPPED: ;
      default:     predict_numeral(v);
    endcase
  endtask

  task automatic check_word();
    numeral_word_t w;
    words_seen++;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word char=%02h last=%0b", character, last));
    end else begin
      w = expected_words.pop_front();
      if (character !== w.ch)
        report_mismatch($sformatf("word %0d: char %02h, expected %02h",
                                  words_seen, character, w.ch));
      if (last !== w.last)
        report_mismatch($sformatf("word %0d: last %0b, expected %0b",
                                  words_seen, last, w.last));
    end
  endtask

  initial begin : drain
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && char_valid && char_ready) check_word();
      if (words_seen == HOLD_AT_WORD && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        char_ready <= 1'b0;
        hold_left--;
      end else if (words_seen >= 1500 && words_seen < 2300) begin
        char_ready <= 1'b1;
      end else begin
        char_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] v;
    add_row(0,    ROW_LITERAL,   "");
    add_row(1,    ROW_LITERAL,   "I");
    add_row(3999, ROW_LITERAL,   "MMMCMXCIX");
    add_row(3888, ROW_LITERAL,   "MMMDCCCLXXXVIII");
    add_row(4000, ROW_DROPPED,   "");
    add_row(4095, ROW_DROPPED,   "");
    add_row(4,    ROW_LITERAL,   "IV");
    add_row(9,    ROW_LITERAL,   "IX");
    add_row(40,   ROW_LITERAL,   "XL");
    add_row(90,   ROW_LITERAL,   "XC");
    add_row(400,  ROW_LITERAL,   "CD");
    add_row(900,  ROW_LITERAL,   "CM");
    add_row(5,    ROW_LITERAL,   "V");
    add_row(8,    ROW_LITERAL,   "VIII");
    add_row(1000, ROW_LITERAL,   "M");
    add_row(0,    ROW_LITERAL,   "");
    add_row(2048, ROW_PREDICTED, "");
    add_row(1994, ROW_PREDICTED, "");
    add_row(444,  ROW_PREDICTED, "");
    add_row(999,  ROW_PREDICTED, "");
    add_row(2730, ROW_PREDICTED, "");
    add_row(1365, ROW_PREDICTED, "");
    add_row(3,    ROW_PREDICTED, "");

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < row_value.size(); i++)
      send_value(row_value[i], row_kind[i], row_text[i], idle_gap(i));

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == PAUSE_AT) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
      end
      v = random_value();
      send_value(v, ROW_PREDICTED, "", idle_gap(i));
    end
    item_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d words still expected", expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: roman_numeral_encoder.f
rtl/rne_pkg.sv
rtl/rne_seq.sv
rtl/roman_numeral_encoder.sv
sim/roman_numeral_encoder_test.sv
